[hw/rtl/mvn_pkg.sv]
// Shared types and constants of the mesh vertex normal generator.
package mvn_pkg;

	localparam int INDEX_W = 10;
	localparam int POS_W   = 16;
	localparam int SUM_W   = 48;
	localparam int NORM_W  = 16;
	localparam int MAX_DEPTH = 1 << INDEX_W;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TRI   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]               op;
		logic [INDEX_W-1:0]       vertex_index;
		logic [INDEX_W-1:0]       corner_b;
		logic [INDEX_W-1:0]       corner_c;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} in_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic                     degenerate;
		logic                     index_error;
	} out_t;

	typedef enum logic [2:0] {
		CMD_WRITE,
		CMD_TRI_IDX,
		CMD_TRI_FLAT,
		CMD_READ,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic [INDEX_W-1:0]       va;
		logic [INDEX_W-1:0]       vb;
		logic [INDEX_W-1:0]       vc;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} cmd_t;

endpackage

[hw/rtl/mvn_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mvn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mvn_front.sv]
// Front end: accepts input beats, checks indices and queues commands for the back end.
module mvn_front #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mvn_pkg::in_t  item,
	input  logic          use_indices,
	input  logic          clearing,
	output logic          cmd_valid,
	output mvn_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import mvn_pkg::*;

	localparam logic [16:0] LIMIT = 17'(VERTEX_DEPTH);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_new;
	logic       keep;
	logic       accept;
	logic       enq;
	logic       deq;
	logic       bad_a;
	logic       bad_b;
	logic       bad_c;
	logic       bad_flat;

	assign bad_a    = 17'(item.vertex_index) >= LIMIT;
	assign bad_b    = 17'(item.corner_b) >= LIMIT;
	assign bad_c    = 17'(item.corner_c) >= LIMIT;
	assign bad_flat = (17'(item.vertex_index) + 17'd2) >= LIMIT;

	always_comb begin
		cmd_new.va    = item.vertex_index;
		cmd_new.vb    = item.corner_b;
		cmd_new.vc    = item.corner_c;
		cmd_new.pos_x = item.pos_x;
		cmd_new.pos_y = item.pos_y;
		cmd_new.pos_z = item.pos_z;
		cmd_new.kind  = CMD_ERROR;
		keep          = 1'b1;
		unique case (item.op)
			OP_WRITE: begin
				cmd_new.kind = bad_a ? CMD_ERROR : CMD_WRITE;
			end
			OP_TRI: begin
				if (use_indices) begin
					cmd_new.kind = (bad_a || bad_b || bad_c) ? CMD_ERROR : CMD_TRI_IDX;
				end else begin
					cmd_new.kind = bad_flat ? CMD_ERROR : CMD_TRI_FLAT;
					cmd_new.vb   = item.vertex_index + INDEX_W'(1);
					cmd_new.vc   = item.vertex_index + INDEX_W'(2);
				end
			end
			OP_READ: begin
				cmd_new.kind = bad_a ? CMD_ERROR : CMD_READ;
			end
			OP_NONE: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == 2'd2) || clearing;
	assign accept    = push && !full;
	assign enq       = accept && keep;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = slot_q[rd_ptr_q];
	assign deq       = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(enq) - 2'(deq);
		end
	end

endmodule

[hw/rtl/mvn_norm.sv]
// Iterative normalizer: scales a 48-bit vector to unit length in Q1.14.
module mvn_norm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [47:0]        s_x,
	input  logic signed [47:0]        s_y,
	input  logic signed [47:0]        s_z,
	output logic                      done,
	output mvn_pkg::out_t             result
);
	import mvn_pkg::*;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHR,
		N_SHL,
		N_SQ,
		N_SQRT,
		N_DIVSET,
		N_DIV
	} nstate_t;

	localparam logic [47:0] HI_LIM = 48'd1 << 30;
	localparam logic [47:0] LO_LIM = 48'd1 << 29;

	nstate_t      state_q;
	logic [47:0]  m_q [3];
	logic [2:0]   neg_q;
	logic [47:0]  mx_q;
	logic [59:0]  prod_q;
	logic [61:0]  n2_q;
	logic [1:0]   cnt_q;
	logic [61:0]  v_q;
	logic [61:0]  r_q;
	logic [60:0]  bit_q;
	logic [44:0]  rem_q [3];
	logic [44:0]  den_q;
	logic [14:0]  q_q [3];
	logic [3:0]   dcnt_q;
	logic [47:0]  mag [3];
	logic [47:0]  mx_in;
	logic [29:0]  sq_op;
	logic [61:0]  trial;

	always_comb begin
		mag[0] = s_x[47] ? 48'(-s_x) : 48'(s_x);
		mag[1] = s_y[47] ? 48'(-s_y) : 48'(s_y);
		mag[2] = s_z[47] ? 48'(-s_z) : 48'(s_z);
		mx_in  = (mag[0] > mag[1]) ? mag[0] : mag[1];
		if (mag[2] > mx_in) begin
			mx_in = mag[2];
		end
	end

	always_comb begin
		unique case (cnt_q)
			2'd0:    sq_op = m_q[0][29:0];
			2'd1:    sq_op = m_q[1][29:0];
			2'd2:    sq_op = m_q[2][29:0];
			default: sq_op = '0;
		endcase
	end

	assign trial = r_q + 62'(bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
			dcnt_q  <= '0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int k = 0; k < 3; k++) begin
							m_q[k] <= mag[k];
						end
						neg_q <= {s_z[47], s_y[47], s_x[47]};
						mx_q  <= mx_in;
						if (mx_in == '0) begin
							result <= out_t'{norm_x: '0, norm_y: '0, norm_z: '0,
								degenerate: 1'b1, index_error: 1'b0};
							done   <= 1'b1;
						end else begin
							state_q <= N_SHR;
						end
					end
				end
				N_SHR: begin
					if (mx_q >= HI_LIM) begin
						mx_q <= mx_q >> 1;
						for (int k = 0; k < 3; k++) begin
							m_q[k] <= m_q[k] >> 1;
						end
					end else begin
						state_q <= N_SHL;
					end
				end
				N_SHL: begin
					if (mx_q < LO_LIM) begin
						mx_q <= mx_q << 1;
						for (int k = 0; k < 3; k++) begin
							m_q[k] <= m_q[k] << 1;
						end
					end else begin
						state_q <= N_SQ;
						cnt_q   <= '0;
						n2_q    <= '0;
					end
				end
				N_SQ: begin
					prod_q <= sq_op * sq_op;
					if (cnt_q != 2'd0) begin
						n2_q <= n2_q + 62'(prod_q);
					end
					if (cnt_q == 2'd3) begin
						v_q     <= n2_q + 62'(prod_q);
						r_q     <= '0;
						bit_q   <= 61'd1 << 60;
						state_q <= N_SQRT;
					end
					cnt_q <= cnt_q + 2'd1;
				end
				N_SQRT: begin
					if (v_q >= trial) begin
						v_q <= v_q - trial;
						r_q <= (r_q >> 1) + 62'(bit_q);
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 61'd1) begin
						state_q <= N_DIVSET;
					end
				end
				N_DIVSET: begin
					den_q <= {r_q[30:0], 14'd0};
					for (int k = 0; k < 3; k++) begin
						rem_q[k] <= {1'b0, m_q[k][29:0], 14'd0} + 45'(r_q[31:1]);
						q_q[k]   <= '0;
					end
					dcnt_q  <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					for (int k = 0; k < 3; k++) begin
						if (rem_q[k] >= den_q) begin
							rem_q[k] <= rem_q[k] - den_q;
							q_q[k]   <= {q_q[k][13:0], 1'b1};
						end else begin
							q_q[k] <= {q_q[k][13:0], 1'b0};
						end
					end
					den_q  <= den_q >> 1;
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) begin
						result.norm_x      <= neg_q[0] ? -{1'b0, q_q[0]} : {1'b0, q_q[0]};
						result.norm_y      <= neg_q[1] ? -{1'b0, q_q[1]} : {1'b0, q_q[1]};
						result.norm_z      <= neg_q[2] ? -{1'b0, q_q[2]} : {1'b0, q_q[2]};
						result.degenerate  <= 1'b0;
						result.index_error <= 1'b0;
						done               <= 1'b1;
						state_q            <= N_IDLE;
					end
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/mvn_back.sv]
// Back end: sequencer that runs commands against the position and normal sum memories.
module mvn_back #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mvn_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          clearing,
	output logic          empty,
	input  logic          pop,
	output mvn_pkg::out_t result
);
	import mvn_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_WRITE,
		B_RA,
		B_RB,
		B_RC,
		B_RCAP,
		B_EDGE,
		B_MUL,
		B_SUMRD,
		B_SUMWR,
		B_RDADDR,
		B_RDCAP,
		B_NORM,
		B_EMIT
	} bstate_t;

	bstate_t             state_q;
	cmd_t                cmd_q;
	logic [AW-1:0]       clr_q;
	logic signed [15:0]  pa_q [3];
	logic signed [15:0]  pb_q [3];
	logic signed [15:0]  pc_q [3];
	logic signed [16:0]  e1_q [3];
	logic signed [16:0]  e2_q [3];
	logic signed [33:0]  prod_q;
	logic signed [34:0]  n_q [3];
	logic [2:0]          mi_q;
	logic [1:0]          ck_q;
	out_t                res_q;
	logic                out_vld_q;

	logic                pos_we;
	logic [AW-1:0]       pos_waddr;
	logic [47:0]         pos_wdata;
	logic [AW-1:0]       pos_raddr;
	logic [47:0]         pos_rdata;
	logic                sum_we;
	logic [AW-1:0]       sum_waddr;
	logic [143:0]        sum_wdata;
	logic [AW-1:0]       sum_raddr;
	logic [143:0]        sum_rdata;
	logic [AW-1:0]       corner;
	logic signed [16:0]  op_a;
	logic signed [16:0]  op_b;
	logic                norm_start;
	logic                norm_done;
	out_t                norm_res;

	function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
		input logic signed [34:0] n);
		logic signed [48:0] t;
		t = 49'(s) + 49'(n);
		if (t[48] != t[47]) begin
			return t[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
		return t[47:0];
	endfunction

	mvn_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	mvn_ram #(.WIDTH(144), .DEPTH(DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.s_x    (sum_rdata[143:96]),
		.s_y    (sum_rdata[95:48]),
		.s_z    (sum_rdata[47:0]),
		.done   (norm_done),
		.result (norm_res)
	);

	always_comb begin
		unique case (ck_q)
			2'd0:    corner = cmd_q.va[AW-1:0];
			2'd1:    corner = cmd_q.vb[AW-1:0];
			default: corner = cmd_q.vc[AW-1:0];
		endcase
	end

	always_comb begin
		unique case (mi_q)
			3'd0:    begin op_a = e1_q[1]; op_b = e2_q[2]; end
			3'd1:    begin op_a = e1_q[2]; op_b = e2_q[1]; end
			3'd2:    begin op_a = e1_q[2]; op_b = e2_q[0]; end
			3'd3:    begin op_a = e1_q[0]; op_b = e2_q[2]; end
			3'd4:    begin op_a = e1_q[0]; op_b = e2_q[1]; end
			3'd5:    begin op_a = e1_q[1]; op_b = e2_q[0]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		pos_we     = state_q == B_WRITE;
		pos_waddr  = cmd_q.va[AW-1:0];
		pos_wdata  = {cmd_q.pos_x, cmd_q.pos_y, cmd_q.pos_z};
		pos_raddr  = cmd_q.va[AW-1:0];
		sum_we     = 1'b0;
		sum_waddr  = corner;
		sum_wdata  = '0;
		sum_raddr  = corner;
		norm_start = state_q == B_RDCAP;
		unique case (state_q)
			B_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_q;
			end
			B_WRITE: begin
				sum_we    = 1'b1;
				sum_waddr = cmd_q.va[AW-1:0];
			end
			B_RB: pos_raddr = cmd_q.vb[AW-1:0];
			B_RC: pos_raddr = cmd_q.vc[AW-1:0];
			B_SUMWR: begin
				sum_we = 1'b1;
				if (cmd_q.kind == CMD_TRI_IDX) begin
					sum_wdata = {sat_add(sum_rdata[143:96], n_q[0]),
						sat_add(sum_rdata[95:48], n_q[1]),
						sat_add(sum_rdata[47:0], n_q[2])};
				end else begin
					sum_wdata = {48'(n_q[0]), 48'(n_q[1]), 48'(n_q[2])};
				end
			end
			B_RDADDR: sum_raddr = cmd_q.va[AW-1:0];
			default: begin
			end
		endcase
	end

	assign cmd_take = (state_q == B_IDLE) && cmd_valid;
	assign clearing = state_q == B_CLEAR;
	assign empty    = !out_vld_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_RB:   for (int k = 0; k < 3; k++) pa_q[k] <= pos_rdata[47-16*k -: 16];
			B_RC:   for (int k = 0; k < 3; k++) pb_q[k] <= pos_rdata[47-16*k -: 16];
			B_RCAP: for (int k = 0; k < 3; k++) pc_q[k] <= pos_rdata[47-16*k -: 16];
			B_EDGE: begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= 17'(pb_q[k]) - 17'(pa_q[k]);
					e2_q[k] <= 17'(pc_q[k]) - 17'(pa_q[k]);
				end
			end
			B_MUL: begin
				prod_q <= op_a * op_b;
				unique case (mi_q)
					3'd1:    n_q[0] <= 35'(prod_q);
					3'd2:    n_q[0] <= n_q[0] - 35'(prod_q);
					3'd3:    n_q[1] <= 35'(prod_q);
					3'd4:    n_q[1] <= n_q[1] - 35'(prod_q);
					3'd5:    n_q[2] <= 35'(prod_q);
					3'd6:    n_q[2] <= n_q[2] - 35'(prod_q);
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			mi_q      <= '0;
			ck_q      <= '0;
			out_vld_q <= 1'b0;
			cmd_q     <= '0;
			res_q     <= '0;
			result    <= '0;
		end else begin
			if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						ck_q  <= '0;
						unique case (cmd.kind)
							CMD_WRITE:    state_q <= B_WRITE;
							CMD_TRI_IDX,
							CMD_TRI_FLAT: state_q <= B_RA;
							CMD_READ:     state_q <= B_RDADDR;
							default: begin
								res_q   <= out_t'{norm_x: '0, norm_y: '0, norm_z: '0,
									degenerate: 1'b0, index_error: 1'b1};
								state_q <= B_EMIT;
							end
						endcase
					end
				end
				B_WRITE:  state_q <= B_IDLE;
				B_RA:     state_q <= B_RB;
				B_RB:     state_q <= B_RC;
				B_RC:     state_q <= B_RCAP;
				B_RCAP:   state_q <= B_EDGE;
				B_EDGE: begin
					mi_q    <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					mi_q <= mi_q + 3'd1;
					if (mi_q == 3'd6) begin
						state_q <= B_SUMRD;
					end
				end
				B_SUMRD:  state_q <= B_SUMWR;
				B_SUMWR: begin
					ck_q <= ck_q + 2'd1;
					state_q <= (ck_q == 2'd2) ? B_IDLE : B_SUMRD;
				end
				B_RDADDR: state_q <= B_RDCAP;
				B_RDCAP:  state_q <= B_NORM;
				B_NORM: begin
					if (norm_done) begin
						res_q   <= norm_res;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (!out_vld_q) begin
						result    <= res_q;
						out_vld_q <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/mesh_vertex_normal_generator.sv]
// Top level of the mesh vertex normal generator.
// After reset the block sweeps the min(VERTEX_DEPTH, 1024) entries of the normal sum memory
// once, one entry per cycle; full stays high during that sweep. A two-entry command queue
// separates the front end from a sequencer that handles one command at a time. A triangle
// takes three position reads, six products on one shared multiplier and three writes of the
// sums, which add to the stored sums in indexed mode and overwrite them in flat mode. A read
// of a zero sum gives a degenerate result without normalizing; any other normal read runs
// through the one-bit-per-cycle normalizing shift, the 31-step square root and the dividers.
// Results wait in an output register until popped.
module mesh_vertex_normal_generator #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mvn_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output mvn_pkg::out_t result,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import mvn_pkg::*;

	localparam int DEPTH_USED = (VERTEX_DEPTH < MAX_DEPTH) ? VERTEX_DEPTH : MAX_DEPTH;

	logic use_indices_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_indices_q <= 1'b0;
		end else if (cfg_we) begin
			use_indices_q <= cfg_wdata;
		end
	end

	mvn_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.use_indices (use_indices_q),
		.clearing    (clearing),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take)
	);

	mvn_back #(.DEPTH(DEPTH_USED)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
